[rtl/hxl_pkg.sv]
// Shared types and constants for the hex text memory loader.
// Character codes, parser mode encoding and the result record.
// No dependencies.
`timescale 1ns / 1ps

package hxl_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int OUT_ADDR_W    = 16;
	localparam int CHAR_W        = 8;
	localparam int BYTE_W        = 8;
	// result beat: 1 + 16 + 8 + 1 + 16 = 42 bits, padded to 48
	localparam int RES_BITS      = 1 + OUT_ADDR_W + BYTE_W + 1 + OUT_ADDR_W;
	localparam int RES_TDATA_W   = ((RES_BITS + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CHAR_AT     = 8'h40;
	localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UP_F   = 8'h46;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOW_F  = 8'h66;

	typedef enum logic [2:0] {
		MODE_DATA  = 3'b001,
		MODE_ADDR  = 3'b010,
		MODE_ENTRY = 3'b100
	} hxl_mode_t;

	typedef struct packed {
		logic                  write_valid;
		logic [OUT_ADDR_W-1:0] write_address;
		logic [BYTE_W-1:0]     write_data;
		logic                  entry_valid;
		logic [OUT_ADDR_W-1:0] entry_point;
	} hxl_result_t;

endpackage

[rtl/hxl_step.sv]
// Combinational parser step: next state and result for one character.
// Uses hxl_pkg for character codes, mode encoding and the result record.
`timescale 1ns / 1ps

module hxl_step #(
	parameter int ADDR_BITS = hxl_pkg::ADDR_BITS_DEF
) (
	input  logic [hxl_pkg::CHAR_W-1:0] char_code,
	input  logic                       line_end,
	input  hxl_pkg::hxl_mode_t         mode,
	input  logic [ADDR_BITS-1:0]       load_address,
	input  logic [hxl_pkg::BYTE_W-1:0] byte_value,
	input  logic                       byte_pending,
	input  logic [ADDR_BITS-1:0]       start_point,
	output hxl_pkg::hxl_mode_t         mode_nx,
	output logic [ADDR_BITS-1:0]       load_address_nx,
	output logic [hxl_pkg::BYTE_W-1:0] byte_value_nx,
	output logic                       byte_pending_nx,
	output logic [ADDR_BITS-1:0]       start_point_nx,
	output hxl_pkg::hxl_result_t       result
);

	logic                       is_hex;
	logic [3:0]                 nibble;
	logic                       wv;
	logic                       ev;
	logic [ADDR_BITS-1:0]       wa;
	logic [hxl_pkg::BYTE_W-1:0] wd;
	logic [ADDR_BITS+15:0]      wa_ext;
	logic [ADDR_BITS+15:0]      ep_ext;
	logic [hxl_pkg::CHAR_W-1:0] diff;

	// hex digit decode, either case
	always_comb begin
		is_hex = 1'b0;
		diff   = '0;
		if (char_code >= hxl_pkg::CHAR_ZERO && char_code <= hxl_pkg::CHAR_NINE) begin
			is_hex = 1'b1;
			diff   = char_code - hxl_pkg::CHAR_ZERO;
		end else if (char_code >= hxl_pkg::CHAR_LOW_A && char_code <= hxl_pkg::CHAR_LOW_F) begin
			is_hex = 1'b1;
			diff   = char_code - hxl_pkg::CHAR_LOW_A + 8'd10;
		end else if (char_code >= hxl_pkg::CHAR_UP_A && char_code <= hxl_pkg::CHAR_UP_F) begin
			is_hex = 1'b1;
			diff   = char_code - hxl_pkg::CHAR_UP_A + 8'd10;
		end
		nibble = diff[3:0];
	end

	always_comb begin
		mode_nx         = mode;
		load_address_nx = load_address;
		byte_value_nx   = byte_value;
		byte_pending_nx = byte_pending;
		start_point_nx  = start_point;
		wv = 1'b0;
		ev = 1'b0;
		wa = '0;
		wd = '0;

		if (char_code == hxl_pkg::CHAR_AT) begin
			if (byte_pending) begin
				wv = 1'b1;
				wa = load_address;
				wd = byte_value;
				load_address_nx = load_address + ADDR_BITS'(1);
			end
			byte_pending_nx = 1'b0;
			mode_nx         = hxl_pkg::MODE_ENTRY;
			start_point_nx  = '0;
			ev              = 1'b1;
		end else if (char_code == hxl_pkg::CHAR_COLON) begin
			// flush writes at the old address; the address field restarts anyway
			if (byte_pending) begin
				wv = 1'b1;
				wa = load_address;
				wd = byte_value;
			end
			byte_pending_nx = 1'b0;
			mode_nx         = hxl_pkg::MODE_ADDR;
			load_address_nx = '0;
		end else if (char_code == hxl_pkg::CHAR_SPACE) begin
			if (byte_pending && mode != hxl_pkg::MODE_ADDR && mode != hxl_pkg::MODE_ENTRY) begin
				wv = 1'b1;
				wa = load_address;
				wd = byte_value;
				load_address_nx = load_address + ADDR_BITS'(1);
			end
			byte_pending_nx = 1'b0;
			mode_nx         = hxl_pkg::MODE_DATA;
			byte_value_nx   = '0;
		end else if (is_hex) begin
			unique case (mode)
				hxl_pkg::MODE_ADDR: begin
					load_address_nx = {load_address[ADDR_BITS-5:0], nibble};
				end
				hxl_pkg::MODE_ENTRY: begin
					start_point_nx = {start_point[ADDR_BITS-5:0], nibble};
					ev             = 1'b1;
				end
				default: begin
					byte_value_nx = {byte_value[3:0], nibble};
				end
			endcase
			byte_pending_nx = 1'b1;
		end

		// line end behaves like a trailing space; a prior write already cleared pending
		if (line_end) begin
			if (byte_pending_nx && mode_nx != hxl_pkg::MODE_ADDR
			    && mode_nx != hxl_pkg::MODE_ENTRY) begin
				wv = 1'b1;
				wa = load_address_nx;
				wd = byte_value_nx;
				load_address_nx = load_address_nx + ADDR_BITS'(1);
			end
			byte_pending_nx = 1'b0;
			mode_nx         = hxl_pkg::MODE_DATA;
			byte_value_nx   = '0;
		end
	end

	assign wa_ext = {16'b0, wa};
	assign ep_ext = {16'b0, start_point_nx};

	assign result.write_valid   = wv;
	assign result.write_address = wa_ext[hxl_pkg::OUT_ADDR_W-1:0];
	assign result.write_data    = wd;
	assign result.entry_valid   = ev;
	assign result.entry_point   = ep_ext[hxl_pkg::OUT_ADDR_W-1:0];

endmodule

[rtl/hex_text_memory_loader.sv]
// Hex text memory loader top level: input register, parser state, result register.
// Depends on hxl_pkg and hxl_step.
`timescale 1ns / 1ps
//
// Usage:
//   Slave side carries one ASCII character per beat on s_tdata, with s_tlast
//   set when the line ends after that character. Master side returns exactly
//   one result beat per input beat: a memory byte write (valid, address, data)
//   and the current entry point with a flag when this beat updated it.
//   The input beat passes through the input register, then the parser step
//   runs from that register and the parser state into the result register.
//   Throughput is one character per cycle while m_tready is high; the parser state
//   update is combinational shift and compare logic, so one beat follows the next directly.
//   When the receiver stalls, the result register holds its beat and the input
//   register takes one more beat if it is empty, after which s_tready drops until
//   m_tready returns.
//   Reset (arst_n low) clears both registers' valid flags and sets the parser
//   to data mode with address, byte, pending flag and entry point at zero.

module hex_text_memory_loader #(
	parameter int ADDR_BITS = hxl_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hxl_pkg::CHAR_W-1:0]      s_tdata,  // [7:0] char_code
	input  logic                            s_tlast,  // line_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] write_valid, [16:1] write_address, [24:17] write_data,
	// [25] entry_valid, [41:26] entry_point, [47:42] zero
	output logic [hxl_pkg::RES_TDATA_W-1:0] m_tdata
);

	logic                       valid_s1;
	logic [hxl_pkg::CHAR_W-1:0] char_s1;
	logic                       eol_s1;
	logic                       advance;

	hxl_pkg::hxl_mode_t         mode_q, mode_nx;
	logic [ADDR_BITS-1:0]       load_address_q, load_address_nx;
	logic [hxl_pkg::BYTE_W-1:0] byte_value_q, byte_value_nx;
	logic                       byte_pending_q, byte_pending_nx;
	logic [ADDR_BITS-1:0]       start_point_q, start_point_nx;

	hxl_pkg::hxl_result_t       step_res;
	hxl_pkg::hxl_result_t       res_q;
	logic                       res_valid_q;

	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eol_s1  <= s_tlast;
		end
	end

	hxl_step #(
		.ADDR_BITS(ADDR_BITS)
	) u_step (
		.char_code       (char_s1),
		.line_end        (eol_s1),
		.mode            (mode_q),
		.load_address    (load_address_q),
		.byte_value      (byte_value_q),
		.byte_pending    (byte_pending_q),
		.start_point     (start_point_q),
		.mode_nx         (mode_nx),
		.load_address_nx (load_address_nx),
		.byte_value_nx   (byte_value_nx),
		.byte_pending_nx (byte_pending_nx),
		.start_point_nx  (start_point_nx),
		.result          (step_res)
	);

	// parser state commits only when the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= hxl_pkg::MODE_DATA;
			load_address_q <= '0;
			byte_value_q   <= '0;
			byte_pending_q <= 1'b0;
			start_point_q  <= '0;
		end else if (advance) begin
			mode_q         <= mode_nx;
			load_address_q <= load_address_nx;
			byte_value_q   <= byte_value_nx;
			byte_pending_q <= byte_pending_nx;
			start_point_q  <= start_point_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {
		(hxl_pkg::RES_TDATA_W - hxl_pkg::RES_BITS)'(0),
		res_q.entry_point,
		res_q.entry_valid,
		res_q.write_data,
		res_q.write_address,
		res_q.write_valid
	};

endmodule

[rtl/hxl_checker.sv]
// Port-level checker for the hex text memory loader, bound to the top level.
// Depends on hxl_pkg and hex_text_memory_loader.
`timescale 1ns / 1ps

module hxl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [hxl_pkg::CHAR_W-1:0]      s_tdata,
	input logic                            s_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hxl_pkg::RES_TDATA_W-1:0] m_tdata
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// a ready receiver never backs up the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although output is ready");

	// accepted beat passes the input register and shows up when the receiver takes in between
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready |=> m_tvalid)
		else $error("result beat missing after accepted input");

	// no write means zeroed write fields
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[24:1] == 24'd0)
		else $error("write fields nonzero without write");

	// an edge seen in reset leaves the result side empty
	a_reset: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	wire unused_ok = &{1'b0, s_tdata, s_tlast};

endmodule

bind hex_text_memory_loader hxl_checker u_hxl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
